/* src/assert_macros.svh */
// Assertion macros used by the checker module.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the default clk_i / rst_ni names.
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/rgd_pkg.sv */
// Shared types and constants for the rotating grille decryptor.
// No dependencies; used by rgd_ctrl, rgd_datapath and the top level.
package rgd_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned CFG_W  = 4;
  localparam logic [DATA_W-1:0] HOLE_CHAR = 8'h2E;
  localparam logic [CFG_W-1:0]  GRID_SIZE_RST = 4'd4;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DEC_START,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SCAN_WR,
    ST_VERIFY,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_INVALID
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic in_accept;
    logic dec_start;
    logic hole_rd;
    logic cipher_rd;
    logic plain_wr;
    logic scan_adv;
    logic plain_rd;
    logic out_char;
    logic out_inv;
  } cmd_t;

  typedef struct packed {
    logic last_cipher;
    logic holes_ok;
    logic take_ok;
    logic scan_last;
    logic all_covered;
    logic emit_last;
    logic out_free;
  } status_t;

endpackage

/* src/rgd_ctrl.sv */
// Sequencer for the rotating grille decryptor: load, scan, verify, emit.
// Depends on rgd_pkg; drives rgd_datapath through cmd_t / status_t.
module rgd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  rgd_pkg::status_t st_i,
  output rgd_pkg::cmd_t    cmd_o
);

  rgd_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rgd_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rgd_pkg::ST_LOAD: begin
        if (in_valid_i && st_i.last_cipher) state_d = rgd_pkg::ST_DEC_START;
      end
      rgd_pkg::ST_DEC_START: begin
        state_d = st_i.holes_ok ? rgd_pkg::ST_SCAN_RD : rgd_pkg::ST_INVALID;
      end
      rgd_pkg::ST_SCAN_RD: state_d = rgd_pkg::ST_SCAN_CHK;
      rgd_pkg::ST_SCAN_CHK: begin
        if (st_i.take_ok) begin
          state_d = rgd_pkg::ST_SCAN_WR;
        end else begin
          state_d = st_i.scan_last ? rgd_pkg::ST_VERIFY : rgd_pkg::ST_SCAN_RD;
        end
      end
      rgd_pkg::ST_SCAN_WR: begin
        state_d = st_i.scan_last ? rgd_pkg::ST_VERIFY : rgd_pkg::ST_SCAN_RD;
      end
      rgd_pkg::ST_VERIFY: begin
        state_d = st_i.all_covered ? rgd_pkg::ST_EMIT_RD : rgd_pkg::ST_INVALID;
      end
      rgd_pkg::ST_EMIT_RD: state_d = rgd_pkg::ST_EMIT_LD;
      rgd_pkg::ST_EMIT_LD: begin
        if (st_i.out_free) begin
          state_d = st_i.emit_last ? rgd_pkg::ST_LOAD : rgd_pkg::ST_EMIT_RD;
        end
      end
      rgd_pkg::ST_INVALID: begin
        if (st_i.out_free) state_d = rgd_pkg::ST_LOAD;
      end
      default: state_d = rgd_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      rgd_pkg::ST_LOAD: begin
        cmd_o.in_ready  = 1'b1;
        cmd_o.in_accept = in_valid_i;
      end
      rgd_pkg::ST_DEC_START: cmd_o.dec_start = 1'b1;
      rgd_pkg::ST_SCAN_RD:   cmd_o.hole_rd = 1'b1;
      rgd_pkg::ST_SCAN_CHK: begin
        cmd_o.cipher_rd = st_i.take_ok;
        cmd_o.scan_adv  = !st_i.take_ok;
      end
      rgd_pkg::ST_SCAN_WR: begin
        cmd_o.plain_wr = 1'b1;
        cmd_o.scan_adv = 1'b1;
      end
      rgd_pkg::ST_VERIFY:  ;
      rgd_pkg::ST_EMIT_RD: cmd_o.plain_rd = 1'b1;
      rgd_pkg::ST_EMIT_LD: cmd_o.out_char = st_i.out_free;
      rgd_pkg::ST_INVALID: cmd_o.out_inv = st_i.out_free;
      default: ;
    endcase
  end

endmodule

/* src/rgd_datapath.sv */
// Datapath: grille, cipher and plaintext stores, counts, scan counters, output register.
// Depends on rgd_pkg; controlled by rgd_ctrl.
module rgd_datapath #(
  parameter int unsigned MAX_SIDE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rgd_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic [rgd_pkg::DATA_W-1:0] in_byte_i,
  input  logic                       in_action_i,
  input  rgd_pkg::cmd_t              cmd_i,
  output rgd_pkg::status_t           st_o,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic [rgd_pkg::DATA_W-1:0] out_char_o,
  output logic                       out_inv_o,
  output logic                       out_last_o
);

  localparam int unsigned CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SIDE);
  localparam int unsigned SIDE_W = $clog2(MAX_SIDE + 1);

  logic [rgd_pkg::CFG_W-1:0] grid_size_q;
  logic [SIDE_W-1:0]         side;
  logic [CNT_W-1:0]          total;
  logic [IDX_W-1:0]          nm1;

  logic [CNT_W-1:0] gcnt_q, ccnt_q, holes_q;
  logic             grille_full;
  logic             is_hole;
  logic [CNT_W-1:0] gidx;

  logic                       hole_mem   [CELLS];
  logic [rgd_pkg::DATA_W-1:0] cipher_mem [CELLS];
  logic [rgd_pkg::DATA_W-1:0] plain_mem  [CELLS];
  logic                       hole_bit_q;
  logic [rgd_pkg::DATA_W-1:0] cipher_rd_q;
  logic [rgd_pkg::DATA_W-1:0] plain_rd_q;

  logic [1:0]       pass_q;
  logic [IDX_W-1:0] row_q, col_q;
  logic [IDX_W-1:0] rot_r, rot_c;
  logic [ADDR_W-1:0] grille_addr, pos;
  logic [CNT_W-1:0] next_q, cover_q;
  logic [CELLS-1:0] covered_q;
  logic [ADDR_W-1:0] emit_q;

  logic                       out_valid_q;
  logic [rgd_pkg::DATA_W-1:0] out_char_q;
  logic                       out_inv_q, out_last_q;

  // Side length in use, clamped to 1..MAX_SIDE
  always_comb begin
    if (grid_size_q == '0) begin
      side = SIDE_W'(1);
    end else if (grid_size_q > rgd_pkg::CFG_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = SIDE_W'(grid_size_q);
    end
  end

  assign total = CNT_W'(side) * CNT_W'(side);
  assign nm1   = IDX_W'(side - SIDE_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= rgd_pkg::GRID_SIZE_RST;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  // Load phase
  assign grille_full = gcnt_q >= total;
  assign is_hole     = in_byte_i == rgd_pkg::HOLE_CHAR;
  assign gidx        = grille_full ? '0 : gcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gcnt_q  <= '0;
      ccnt_q  <= '0;
      holes_q <= '0;
    end else if (cfg_we_i || cmd_i.dec_start) begin
      gcnt_q  <= '0;
      ccnt_q  <= '0;
      holes_q <= '0;
    end else if (cmd_i.in_accept) begin
      if (!in_action_i) begin
        gcnt_q  <= gidx + CNT_W'(1);
        holes_q <= (grille_full ? '0 : holes_q) + CNT_W'(is_hole);
        if (grille_full) ccnt_q <= '0;
      end else if (grille_full) begin
        ccnt_q <= ccnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_accept && !in_action_i) begin
      hole_mem[gidx[ADDR_W-1:0]] <= is_hole;
    end
    if (cmd_i.hole_rd) begin
      hole_bit_q <= hole_mem[grille_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_accept && in_action_i && grille_full) begin
      cipher_mem[ccnt_q[ADDR_W-1:0]] <= in_byte_i;
    end
    if (cmd_i.cipher_rd) begin
      cipher_rd_q <= cipher_mem[next_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.plain_wr) begin
      plain_mem[pos] <= cipher_rd_q;
    end
    if (cmd_i.plain_rd) begin
      plain_rd_q <= plain_mem[emit_q];
    end
  end

  // Grille cell seen by output position (row, col) in the current quarter turn
  always_comb begin
    unique case (pass_q)
      2'd0: begin rot_r = row_q;         rot_c = col_q;         end
      2'd1: begin rot_r = nm1 - col_q;   rot_c = row_q;         end
      2'd2: begin rot_r = nm1 - row_q;   rot_c = nm1 - col_q;   end
      default: begin rot_r = col_q;      rot_c = nm1 - row_q;   end
    endcase
  end

  assign grille_addr = ADDR_W'(CNT_W'(rot_r) * CNT_W'(side) + CNT_W'(rot_c));
  assign pos         = ADDR_W'(CNT_W'(row_q) * CNT_W'(side) + CNT_W'(col_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      next_q    <= '0;
      cover_q   <= '0;
      covered_q <= '0;
      emit_q    <= '0;
    end else if (cmd_i.dec_start) begin
      pass_q    <= '0;
      row_q     <= '0;
      col_q     <= '0;
      next_q    <= '0;
      cover_q   <= '0;
      covered_q <= '0;
      emit_q    <= '0;
    end else begin
      if (cmd_i.scan_adv) begin
        if (col_q == nm1) begin
          col_q <= '0;
          if (row_q == nm1) begin
            row_q  <= '0;
            pass_q <= pass_q + 2'd1;
          end else begin
            row_q <= row_q + IDX_W'(1);
          end
        end else begin
          col_q <= col_q + IDX_W'(1);
        end
      end
      if (cmd_i.cipher_rd) next_q <= next_q + CNT_W'(1);
      if (cmd_i.plain_wr) begin
        covered_q[pos] <= 1'b1;
        if (!covered_q[pos]) cover_q <= cover_q + CNT_W'(1);
      end
      if (cmd_i.out_char) emit_q <= emit_q + ADDR_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_char || cmd_i.out_inv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_char) begin
      out_char_q <= plain_rd_q;
      out_inv_q  <= 1'b0;
      out_last_q <= st_o.emit_last;
    end else if (cmd_i.out_inv) begin
      out_char_q <= '0;
      out_inv_q  <= 1'b1;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_inv_o   = out_inv_q;
  assign out_last_o  = out_last_q;

  always_comb begin
    st_o.last_cipher = in_action_i && grille_full && (ccnt_q == total - CNT_W'(1));
    st_o.holes_ok    = ((CNT_W+2)'(holes_q) << 2) == (CNT_W+2)'(total);
    st_o.take_ok     = hole_bit_q && (next_q < total);
    st_o.scan_last   = (pass_q == 2'd3) && (row_q == nm1) && (col_q == nm1);
    st_o.all_covered = cover_q == total;
    st_o.emit_last   = CNT_W'(emit_q) == total - CNT_W'(1);
    st_o.out_free    = !out_valid_q || out_ready_i;
  end

endmodule

/* src/rotating_grille_decrypt.sv */
// Rotating grille decryptor, top level.
// Instantiates rgd_ctrl and rgd_datapath; uses rgd_pkg.
//
// Usage:
//  - cfg_we_i/cfg_wdata_i write the grid side n (reset 4, 0 acts as 1, above
//    MAX_SIDE acts as MAX_SIDE); a write restarts loading. Write only when idle.
//  - Slave stream: tuser = 0 carries a grille cell ('.' is a hole), tuser = 1
//    a ciphertext byte. n*n grille requests, then n*n ciphertext requests.
//    Ciphertext before the grille is complete is dropped; a grille request
//    after a complete grille starts a new run.
//  - Loading takes one request per cycle. After the last ciphertext request
//    the block stops accepting, scans 4*n*n cells (single-port store reads: a
//    grille read and check per cell, plus a plaintext write per open cell),
//    then emits n*n plaintext bytes, tlast on the last. A bad grille gives one
//    result with tuser = 1, tdata = 0, tlast = 1.
//  - A stalled master side holds its request in the output register and the
//    sequencer waits; the next load begins as soon as the last result is
//    registered.
//  - Reset returns n to 4 and clears all counts; stores need no clearing.
module rotating_grille_decrypt #(
  parameter int unsigned MAX_SIDE = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rgd_pkg::CFG_W-1:0]  cfg_wdata_i,     // grid_size
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [rgd_pkg::DATA_W-1:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic                       s_axis_tuser_i,  // [0] action
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [rgd_pkg::DATA_W-1:0] m_axis_tdata_o,  // [7:0] plain_char
  output logic                       m_axis_tuser_o,  // [0] invalid
  output logic                       m_axis_tlast_o
);

  rgd_pkg::cmd_t    cmd;
  rgd_pkg::status_t st;

  rgd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  rgd_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (s_axis_tdata_i),
    .in_action_i (s_axis_tuser_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_char_o  (m_axis_tdata_o),
    .out_inv_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign s_axis_tready_o = cmd.in_ready;

endmodule

/* src/rgd_checker.sv */
// Port-level checker for rotating_grille_decrypt, bound to the top level.
// Depends on assert_macros.svh and rgd_pkg.
`include "assert_macros.svh"

module rgd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tready_o,
  input logic                       m_axis_tvalid_o,
  input logic                       m_axis_tready_i,
  input logic [rgd_pkg::DATA_W-1:0] m_axis_tdata_o,
  input logic                       m_axis_tuser_o,
  input logic                       m_axis_tlast_o
);

  `ASSERT_DEF(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `ASSERT_DEF(a_inv_last, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o, "invalid result without tlast")
  `ASSERT_DEF(a_inv_zero, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0, "invalid result with nonzero data")
  `ASSERT_DEF(a_no_load_mid, m_axis_tvalid_o && !m_axis_tlast_o |-> !s_axis_tready_o, "input taken during emission")

endmodule

bind rotating_grille_decrypt rgd_checker u_rgd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
